// ----- hw/rtl/stbg_pkg.sv -----
// stbg_pkg: constants, command codes, state type and quarter-wave sine function
// for the sine tone burst generator; depends on nothing
`default_nettype none

package stbg_pkg;

    // default phase accumulator and sine table widths
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 12;

    // field widths
    localparam int CMD_W    = 2;
    localparam int FREQ_W   = 16;
    localparam int MS_W     = 16;
    localparam int AMPIN_W  = 16;
    localparam int AMP_W    = 15;
    localparam int RATE_W   = 18;
    localparam int LEN_W    = 34;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_SAMPLE_RATE = '0;
    localparam logic [RATE_W-1:0]     RATE_RESET      = RATE_W'(16000);

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEEP  = 2'd2;

    // beep preset and amplitude limit
    localparam logic [FREQ_W-1:0]  BEEP_FREQ = FREQ_W'(1000);
    localparam logic [MS_W-1:0]    BEEP_MS   = MS_W'(80);
    localparam logic [AMPIN_W-1:0] BEEP_AMP  = AMPIN_W'(600);
    localparam logic [AMPIN_W-1:0] AMP_LIMIT = AMPIN_W'(32000);

    // burst length: serial multiply by ms, then serial divide by 1000
    localparam int LEN_MUL_STEPS = MS_W;
    localparam int LEN_STEPS     = MS_W + LEN_W;
    localparam int LCNT_W        = $clog2(LEN_STEPS + 1);
    localparam int LREM_W        = 10;
    localparam logic [LREM_W:0] MS_PER_SEC = 11'd1000;

    // q30 constants for the table build
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ROM,
        ST_MUL,
        ST_OUT
    } state_t;

    // quarter-wave sine in q15, horner series with truncation at each step
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j, input int tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        x  = (64'(j) * HALF_PI_Q30) >> (tb - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        v  = ((((x * t) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sine_tone_burst_generator.sv -----
// sine_tone_burst_generator: dds tone burst source with bit-serial setup math,
// stream in/out and apb sample-rate register; depends on stbg_pkg
//
// Each request on the input stream returns exactly one result. A sample tick
// passes through the quadrant address, a registered quarter-wave rom read,
// one 15x15 multiply and the output load before the next request is taken.
// A start or beep request runs two bit-serial units side by side: a restoring
// divider for the phase step, one quotient bit per cycle over 16+PHASE_BITS
// steps, and a shift-add multiply by the duration (16 steps) followed by a
// restoring divide by 1000 (34 steps) for the burst length; it finishes when
// both units are done. A start that is ignored (zero frequency, duration or
// sample rate) and an unused command go straight to the output load. The
// input is taken again as soon as the result sits in the output register,
// even while that result waits on m_tready.
`default_nettype none

module sine_tone_burst_generator #(
    parameter int PHASE_BITS      = stbg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = stbg_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // apb configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [stbg_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [stbg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [stbg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: frequency [15:0], duration_ms [31:16], amplitude [47:32]
    input  wire logic [47:0]                         s_tdata,
    // s_tuser: command [1:0]
    input  wire logic [stbg_pkg::CMD_W-1:0]          s_tuser,
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: sample [15:0]
    output logic      [stbg_pkg::SAMPLE_W-1:0]       m_tdata,
    // m_tuser: sample_valid [0]
    output logic      [0:0]                          m_tuser,
    // m_tlast: last_sample
    output logic                                     m_tlast
);

    localparam int TB         = SINE_TABLE_BITS;
    localparam int J_W        = TB - 1;
    localparam int QUARTER    = 1 << (TB - 2);
    localparam int PDIV_STEPS = stbg_pkg::FREQ_W + PHASE_BITS;
    localparam int PCNT_W     = $clog2(PDIV_STEPS + 1);

    localparam int FREQ_W = stbg_pkg::FREQ_W;
    localparam int MS_W   = stbg_pkg::MS_W;
    localparam int AMP_W  = stbg_pkg::AMP_W;
    localparam int RATE_W = stbg_pkg::RATE_W;
    localparam int LEN_W  = stbg_pkg::LEN_W;
    localparam int LREM_W = stbg_pkg::LREM_W;
    localparam int LCNT_W = stbg_pkg::LCNT_W;
    localparam int MAG_W  = stbg_pkg::MAG_W;
    localparam int SMP_W  = stbg_pkg::SAMPLE_W;

    stbg_pkg::state_t state_reg, state_next;

    logic [RATE_W-1:0]     rate_reg;
    logic [PHASE_BITS-1:0] phase_accum_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [LEN_W-1:0]      samples_left_reg;
    logic [AMP_W-1:0]      tone_amp_reg;

    // phase step divider
    logic [PCNT_W-1:0]     pdiv_cnt_reg;
    logic [FREQ_W-1:0]     pdiv_num_reg;
    logic [RATE_W-1:0]     pdiv_rem_reg;
    logic [PHASE_BITS-1:0] pdiv_quot_reg;

    // burst length multiply/divide
    logic [LCNT_W-1:0]     len_cnt_reg;
    logic [MS_W-1:0]       ms_sh_reg;
    logic [LEN_W-1:0]      len_acc_reg;
    logic [LREM_W-1:0]     lrem_reg;

    // tick datapath
    logic [J_W-1:0]        rom_addr_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [2*MAG_W-1:0]    prod_reg;
    logic                  neg_reg;
    logic                  tick_valid_reg;
    logic                  last_flag_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [SMP_W-1:0]      m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tlast_reg;

    // input field decode
    logic [stbg_pkg::CMD_W-1:0] in_cmd;
    logic [FREQ_W-1:0]          in_freq;
    logic [MS_W-1:0]            in_ms;
    logic [stbg_pkg::AMPIN_W-1:0] in_amp;
    logic [FREQ_W-1:0]          st_freq;
    logic [MS_W-1:0]            st_ms;
    logic [stbg_pkg::AMPIN_W-1:0] st_amp;
    logic                       is_start;
    logic                       start_ok;
    logic                       tick_ok;
    logic                       in_accept;
    logic                       out_load;
    logic                       calc_done;

    assign in_cmd  = s_tuser;
    assign in_freq = s_tdata[15:0];
    assign in_ms   = s_tdata[31:16];
    assign in_amp  = s_tdata[47:32];

    // start parameters, beep uses the preset
    always_comb begin
        is_start = (in_cmd == stbg_pkg::CMD_START) || (in_cmd == stbg_pkg::CMD_BEEP);
        if (in_cmd == stbg_pkg::CMD_BEEP) begin
            st_freq = stbg_pkg::BEEP_FREQ;
            st_ms   = stbg_pkg::BEEP_MS;
            st_amp  = stbg_pkg::BEEP_AMP;
        end else begin
            st_freq = in_freq;
            st_ms   = in_ms;
            st_amp  = in_amp;
        end
        start_ok = is_start && (st_freq != '0) && (st_ms != '0) && (rate_reg != '0);
        tick_ok  = (in_cmd == stbg_pkg::CMD_TICK) && (samples_left_reg != '0);
    end

    // apb register
    logic [stbg_pkg::APB_ADDR_W-3:0] reg_index;
    logic                            cfg_write;

    assign reg_index = paddr[stbg_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        if (reg_index == stbg_pkg::REG_SAMPLE_RATE) begin
            prdata = stbg_pkg::APB_DATA_W'(rate_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= stbg_pkg::RATE_RESET;
        end else if (cfg_write && (reg_index == stbg_pkg::REG_SAMPLE_RATE)) begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    // quarter-wave sine rom, built at elaboration
    logic [MAG_W-1:0] sine_rom [0:QUARTER];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign sine_rom[g] = stbg_pkg::quarter_sine(g, TB);
    end

    // setup units finished
    assign calc_done = (pdiv_cnt_reg == PCNT_W'(PDIV_STEPS)) &&
                       (len_cnt_reg == LCNT_W'(stbg_pkg::LEN_STEPS));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stbg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (start_ok) begin
                        state_next = stbg_pkg::ST_CALC;
                    end else if (tick_ok) begin
                        state_next = stbg_pkg::ST_ROM;
                    end else begin
                        state_next = stbg_pkg::ST_OUT;
                    end
                end
            end
            stbg_pkg::ST_CALC: begin
                if (calc_done) begin
                    state_next = stbg_pkg::ST_OUT;
                end
            end
            stbg_pkg::ST_ROM: begin
                state_next = stbg_pkg::ST_MUL;
            end
            stbg_pkg::ST_MUL: begin
                state_next = stbg_pkg::ST_OUT;
            end
            stbg_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = stbg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stbg_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = (state_reg == stbg_pkg::ST_IDLE);
        out_load = (state_reg == stbg_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stbg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // tone state
    logic [TB-1:0]  tab_idx;
    logic [J_W-1:0] tab_m;

    assign tab_idx = phase_accum_reg[PHASE_BITS-1 -: TB];
    assign tab_m   = J_W'(tab_idx[TB-3:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_accum_reg  <= '0;
            phase_step_reg   <= '0;
            samples_left_reg <= '0;
            tone_amp_reg     <= '0;
        end else if (in_accept && start_ok) begin
            phase_accum_reg <= '0;
            if (st_amp > stbg_pkg::AMP_LIMIT) begin
                tone_amp_reg <= stbg_pkg::AMP_LIMIT[AMP_W-1:0];
            end else begin
                tone_amp_reg <= st_amp[AMP_W-1:0];
            end
        end else if (in_accept && tick_ok) begin
            phase_accum_reg  <= phase_accum_reg + phase_step_reg;
            samples_left_reg <= samples_left_reg - LEN_W'(1);
        end else if ((state_reg == stbg_pkg::ST_CALC) && calc_done) begin
            phase_step_reg   <= pdiv_quot_reg;
            samples_left_reg <= len_acc_reg;
        end
    end

    // phase step divider: one quotient bit a cycle
    logic [RATE_W:0]   pdiv_trial;
    logic              pdiv_ge;

    always_comb begin
        pdiv_trial = {pdiv_rem_reg, pdiv_num_reg[FREQ_W-1]};
        pdiv_ge    = pdiv_trial >= {1'b0, rate_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pdiv_cnt_reg <= '0;
        end else if (in_accept) begin
            pdiv_cnt_reg <= '0;
        end else if ((state_reg == stbg_pkg::ST_CALC) &&
                     (pdiv_cnt_reg != PCNT_W'(PDIV_STEPS))) begin
            pdiv_cnt_reg <= pdiv_cnt_reg + PCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pdiv_num_reg  <= st_freq;
            pdiv_rem_reg  <= '0;
            pdiv_quot_reg <= '0;
        end else if ((state_reg == stbg_pkg::ST_CALC) &&
                     (pdiv_cnt_reg != PCNT_W'(PDIV_STEPS))) begin
            pdiv_num_reg  <= {pdiv_num_reg[FREQ_W-2:0], 1'b0};
            pdiv_quot_reg <= {pdiv_quot_reg[PHASE_BITS-2:0], pdiv_ge};
            if (pdiv_ge) begin
                pdiv_rem_reg <= RATE_W'(pdiv_trial - {1'b0, rate_reg});
            end else begin
                pdiv_rem_reg <= pdiv_trial[RATE_W-1:0];
            end
        end
    end

    // burst length: shift-add multiply, then divide by 1000 in place
    logic [LREM_W:0] lrem_trial;
    logic            lrem_ge;
    logic            len_mul_phase;

    always_comb begin
        len_mul_phase = len_cnt_reg < LCNT_W'(stbg_pkg::LEN_MUL_STEPS);
        lrem_trial    = {lrem_reg, len_acc_reg[LEN_W-1]};
        lrem_ge       = lrem_trial >= stbg_pkg::MS_PER_SEC;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cnt_reg <= '0;
        end else if (in_accept) begin
            len_cnt_reg <= '0;
        end else if ((state_reg == stbg_pkg::ST_CALC) &&
                     (len_cnt_reg != LCNT_W'(stbg_pkg::LEN_STEPS))) begin
            len_cnt_reg <= len_cnt_reg + LCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ms_sh_reg   <= st_ms;
            len_acc_reg <= '0;
            lrem_reg    <= '0;
        end else if ((state_reg == stbg_pkg::ST_CALC) &&
                     (len_cnt_reg != LCNT_W'(stbg_pkg::LEN_STEPS))) begin
            if (len_mul_phase) begin
                ms_sh_reg <= {ms_sh_reg[MS_W-2:0], 1'b0};
                if (ms_sh_reg[MS_W-1]) begin
                    len_acc_reg <= {len_acc_reg[LEN_W-2:0], 1'b0} + LEN_W'(rate_reg);
                end else begin
                    len_acc_reg <= {len_acc_reg[LEN_W-2:0], 1'b0};
                end
            end else begin
                len_acc_reg <= {len_acc_reg[LEN_W-2:0], lrem_ge};
                if (lrem_ge) begin
                    lrem_reg <= LREM_W'(lrem_trial - stbg_pkg::MS_PER_SEC);
                end else begin
                    lrem_reg <= lrem_trial[LREM_W-1:0];
                end
            end
        end
    end

    // tick path: quadrant address, rom read, amplitude multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else if (in_accept) begin
            tick_valid_reg <= tick_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            last_flag_reg <= (samples_left_reg == LEN_W'(1));
            neg_reg       <= tab_idx[TB-1];
            if (tab_idx[TB-2]) begin
                rom_addr_reg <= J_W'(QUARTER) - tab_m;
            end else begin
                rom_addr_reg <= tab_m;
            end
        end
        if (state_reg == stbg_pkg::ST_ROM) begin
            mag_reg <= sine_rom[rom_addr_reg];
        end
        if (state_reg == stbg_pkg::ST_MUL) begin
            prod_reg <= mag_reg * tone_amp_reg;
        end
    end

    // output register
    logic [SMP_W-1:0] sample_mag;

    assign sample_mag = {1'b0, prod_reg[2*MAG_W-1:MAG_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= tick_valid_reg;
            m_tlast_reg <= tick_valid_reg && last_flag_reg;
            if (!tick_valid_reg) begin
                m_tdata_reg <= '0;
            end else if (neg_reg) begin
                m_tdata_reg <= SMP_W'(0) - sample_mag;
            end else begin
                m_tdata_reg <= sample_mag;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_last_needs_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tuser_reg)
        else $error("last sample flagged without a valid sample");

    a_idle_sample_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg |-> (m_tdata_reg == '0))
        else $error("non-sample result carries data");

    a_sample_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_tdata_reg) <= $signed(SMP_W'(32000))) &&
                         ($signed(m_tdata_reg) >= -$signed(SMP_W'(32000))))
        else $error("sample outside amplitude range");

    a_amp_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        tone_amp_reg <= stbg_pkg::AMP_LIMIT[AMP_W-1:0])
        else $error("tone amplitude above limit");

    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken without leaving idle");

endmodule

`default_nettype wire
